// ----- rtl/kt_pkg.sv -----
// Shared types, constants and fixed-point helpers for the two-state Kalman tracker.
`timescale 1ns / 1ps
package kt_pkg;

   localparam int DataW    = 32;
   localparam int FracW    = 16;
   localparam int ProdW    = 2 * DataW;
   localparam int DvdW     = DataW + FracW;
   localparam int CsrW     = 31;
   localparam int DtW      = 17;
   localparam int CsrAddrW = 2;
   localparam int DivSteps = DvdW;
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [CsrAddrW-1:0] CSR_Q_POSITION = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_Q_VELOCITY = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_MEAS_NOISE = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_TIME_STEP  = 2'd3;

   localparam logic [CsrW-1:0]  QPosReset   = 31'd1966;
   localparam logic [CsrW-1:0]  QVelReset   = 31'd1966;
   localparam logic [CsrW-1:0]  RReset      = 31'd2949;
   localparam logic [DtW-1:0]   DtReset     = 17'd262;
   localparam logic [DataW-1:0] CovResetVal = 32'd655;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD,
      OP_M_DT_VEL, OP_XP, OP_M_DT_PV, OP_B00, OP_M_DT_VV, OP_B01,
      OP_M_B01_DT, OP_T, OP_PP, OP_VV, OP_DEN, OP_ERR,
      OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
      OP_M_K0_E, OP_POS, OP_M_K1_E, OP_VEL, OP_M_K0_PP, OP_CPP,
      OP_M_K0_PV, OP_CPV, OP_M_K1_PV, OP_CVV, OP_OUT
   } op_type;

   typedef enum logic {ST_IDLE, ST_RUN} ctrl_state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   localparam int ProgLen = 26;
   localparam int PcW     = $clog2(ProgLen);

   // Sequence run after a request is loaded; each multiply is followed by its accumulate.
   localparam op_type Prog [ProgLen] = '{
      OP_M_DT_VEL, OP_XP, OP_M_DT_PV, OP_B00, OP_M_DT_VV, OP_B01,
      OP_M_B01_DT, OP_T, OP_PP, OP_VV, OP_DEN, OP_ERR,
      OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
      OP_M_K0_E, OP_POS, OP_M_K1_E, OP_VEL, OP_M_K0_PP, OP_CPP,
      OP_M_K0_PV, OP_CPV, OP_M_K1_PV, OP_CVV, OP_OUT
   };

   typedef struct packed {
      logic signed [DataW-1:0] val;
      logic                    clip;
   } satval_type;

   function automatic logic [DataW-1:0] mag(input logic signed [DataW-1:0] v);
      return v[DataW-1] ? DataW'(-v) : DataW'(v);
   endfunction

   function automatic satval_type sat_wide(input logic signed [DataW:0] s);
      satval_type r;
      if (s[DataW] != s[DataW-1]) begin
         r.clip = 1'b1;
         r.val  = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end else begin
         r.clip = 1'b0;
         r.val  = s[DataW-1:0];
      end
      return r;
   endfunction

   // Applies a sign to a magnitude, clipping to the signed data range.
   function automatic satval_type sign_mag(input logic neg, input logic [DvdW-1:0] m);
      satval_type r;
      logic [DvdW-1:0] lim;
      logic [DvdW-1:0] mm;
      lim = DvdW'({1'b0, {(DataW-1){1'b1}}}) + DvdW'(neg);
      mm  = m;
      r.clip = 1'b0;
      if (m > lim) begin
         r.clip = 1'b1;
         mm     = lim;
      end
      r.val = neg ? DataW'(-mm[DataW-1:0]) : mm[DataW-1:0];
      return r;
   endfunction

endpackage

// ----- rtl/kt_datapath.sv -----
// Datapath of the Kalman tracker: state, config, multiplier, accumulator and divider.
`timescale 1ns / 1ps
module kt_datapath import kt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic signed [DataW-1:0]   req_measurement,
   input  logic                      csr_wr_en,
   input  logic [CsrAddrW-1:0]       csr_addr,
   input  logic [CsrW-1:0]           csr_wdata,
   output logic signed [DataW-1:0]   rsp_position_estimate,
   output logic signed [DataW-1:0]   rsp_velocity_estimate,
   output logic                      rsp_saturated
);

   logic [CsrW-1:0] qpos_ff, qvel_ff, r_ff;
   logic [DtW-1:0]  dt_ff;

   logic signed [DataW-1:0] pos_ff, vel_ff, cpp_ff, cpv_ff, cvv_ff;
   logic signed [DataW-1:0] z_ff, xp_ff, b00_ff, b01_ff, pp_ff, vv_ff, den_ff;
   logic signed [DataW-1:0] k0_ff, k1_ff, e_ff;
   logic [ProdW-1:0]        prod_ff;
   logic                    pneg_ff;
   logic                    clip_ff;
   logic [DataW-1:0]        rem0_ff, rem1_ff;
   logic [DvdW-1:0]         dvd0_ff, dvd1_ff;
   logic signed [DataW-1:0] opos_ff, ovel_ff;
   logic                    osat_ff;

   logic signed [DataW-1:0] ma, mb, ax, ay;
   logic                    sub, use_prod;
   logic signed [DataW:0]   sum;
   satval_type              psat, ssat, q0sat, q1sat;
   logic [DataW-1:0]        dmag;
   logic [DataW:0]          r0, r1;
   logic                    acc_clip;

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_M_DT_VEL: begin ma = DataW'({1'b0, dt_ff}); mb = vel_ff; end
         OP_M_DT_PV:  begin ma = DataW'({1'b0, dt_ff}); mb = cpv_ff; end
         OP_M_DT_VV:  begin ma = DataW'({1'b0, dt_ff}); mb = cvv_ff; end
         OP_M_B01_DT: begin ma = b01_ff; mb = DataW'({1'b0, dt_ff}); end
         OP_M_K0_E:   begin ma = k0_ff; mb = e_ff; end
         OP_M_K1_E:   begin ma = k1_ff; mb = e_ff; end
         OP_M_K0_PP:  begin ma = k0_ff; mb = pp_ff; end
         OP_M_K0_PV:  begin ma = k0_ff; mb = b01_ff; end
         OP_M_K1_PV:  begin ma = k1_ff; mb = b01_ff; end
         default: ;
      endcase
   end

   assign psat = sign_mag(pneg_ff, prod_ff[ProdW-1:FracW]);

   always_comb begin
      ax       = '0;
      ay       = psat.val;
      sub      = 1'b0;
      use_prod = 1'b1;
      case (cmd.op)
         OP_XP:  ax = pos_ff;
         OP_B00: ax = cpp_ff;
         OP_B01: ax = cpv_ff;
         OP_T:   ax = b00_ff;
         OP_PP:  begin ax = b00_ff; ay = DataW'({1'b0, qpos_ff}); use_prod = 1'b0; end
         OP_VV:  begin ax = cvv_ff; ay = DataW'({1'b0, qvel_ff}); use_prod = 1'b0; end
         OP_DEN: begin ax = pp_ff;  ay = DataW'({1'b0, r_ff});    use_prod = 1'b0; end
         OP_ERR: begin ax = z_ff;   ay = xp_ff; sub = 1'b1;       use_prod = 1'b0; end
         OP_POS: ax = xp_ff;
         OP_VEL: ax = vel_ff;
         OP_CPP: begin ax = pp_ff;  sub = 1'b1; end
         OP_CPV: begin ax = b01_ff; sub = 1'b1; end
         OP_CVV: begin ax = vv_ff;  sub = 1'b1; end
         default: use_prod = 1'b0;
      endcase
      sum      = sub ? ((DataW+1)'(ax) - (DataW+1)'(ay)) : ((DataW+1)'(ax) + (DataW+1)'(ay));
      ssat     = sat_wide(sum);
      acc_clip = ssat.clip | (use_prod & psat.clip);
   end

   assign dmag  = mag(den_ff);
   assign r0    = {rem0_ff, dvd0_ff[DvdW-1]};
   assign r1    = {rem1_ff, dvd1_ff[DvdW-1]};
   assign q0sat = sign_mag(pp_ff[DataW-1] ^ den_ff[DataW-1], dvd0_ff);
   assign q1sat = sign_mag(b01_ff[DataW-1] ^ den_ff[DataW-1], dvd1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff <= QPosReset;
         qvel_ff <= QVelReset;
         r_ff    <= RReset;
         dt_ff   <= DtReset;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_Q_POSITION: qpos_ff <= csr_wdata;
            CSR_Q_VELOCITY: qvel_ff <= csr_wdata;
            CSR_MEAS_NOISE: r_ff    <= csr_wdata;
            CSR_TIME_STEP:  dt_ff   <= csr_wdata[DtW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vel_ff  <= '0;
         cpp_ff  <= CovResetVal;
         cpv_ff  <= '0;
         cvv_ff  <= CovResetVal;
         clip_ff <= 1'b0;
      end else begin
         prod_ff <= ProdW'(mag(ma)) * ProdW'(mag(mb));
         pneg_ff <= ma[DataW-1] ^ mb[DataW-1];
         case (cmd.op)
            OP_LOAD: begin z_ff <= req_measurement; clip_ff <= 1'b0; end
            OP_XP:   begin xp_ff  <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_B00,
            OP_T:    begin b00_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_B01:  begin b01_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_PP:   begin pp_ff  <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_VV:   begin vv_ff  <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_DEN:  begin den_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_ERR:  begin e_ff   <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_POS:  begin pos_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_VEL:  begin vel_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_CPP:  begin cpp_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_CPV:  begin cpv_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_CVV:  begin cvv_ff <= ssat.val; clip_ff <= clip_ff | acc_clip; end
            OP_DIV_INIT: begin
               rem0_ff <= '0;
               rem1_ff <= '0;
               dvd0_ff <= {mag(pp_ff), {FracW{1'b0}}};
               dvd1_ff <= {mag(b01_ff), {FracW{1'b0}}};
            end
            // One restoring step per cycle on both numerators against the shared divisor.
            OP_DIV_STEP: begin
               if (r0 >= {1'b0, dmag}) begin
                  rem0_ff <= DataW'(r0 - {1'b0, dmag});
                  dvd0_ff <= {dvd0_ff[DvdW-2:0], 1'b1};
               end else begin
                  rem0_ff <= r0[DataW-1:0];
                  dvd0_ff <= {dvd0_ff[DvdW-2:0], 1'b0};
               end
               if (r1 >= {1'b0, dmag}) begin
                  rem1_ff <= DataW'(r1 - {1'b0, dmag});
                  dvd1_ff <= {dvd1_ff[DvdW-2:0], 1'b1};
               end else begin
                  rem1_ff <= r1[DataW-1:0];
                  dvd1_ff <= {dvd1_ff[DvdW-2:0], 1'b0};
               end
            end
            OP_DIV_END: begin
               if (den_ff == '0) begin
                  k0_ff <= '0;
                  k1_ff <= '0;
               end else begin
                  k0_ff   <= q0sat.val;
                  k1_ff   <= q1sat.val;
                  clip_ff <= clip_ff | q0sat.clip | q1sat.clip;
               end
            end
            OP_OUT: begin
               opos_ff <= pos_ff;
               ovel_ff <= vel_ff;
               osat_ff <= clip_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_position_estimate = opos_ff;
   assign rsp_velocity_estimate = ovel_ff;
   assign rsp_saturated         = osat_ff;

endmodule

// ----- rtl/kt_ctrl.sv -----
// Sequencer of the Kalman tracker: request handshake, step program and divide count.
`timescale 1ns / 1ps
module kt_ctrl import kt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   ctrl_state_type       state_ff, state_in;
   logic [PcW-1:0]       pc_ff, pc_in;
   logic [DivCntW-1:0]   cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.op       = OP_NOP;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               pc_in    = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.op = Prog[pc_ff];
            case (Prog[pc_ff])
               OP_DIV_STEP: begin
                  if (cnt_ff == DivCntW'(DivSteps - 1)) begin
                     cnt_in = '0;
                     pc_in  = pc_ff + PcW'(1);
                  end else begin
                     cnt_in = cnt_ff + DivCntW'(1);
                  end
               end
               OP_OUT: begin
                  // The previous request's result must leave the output register first.
                  if (rsp_valid_ff && rsp_stall) begin
                     cmd.op = OP_NOP;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: pc_in = pc_ff + PcW'(1);
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/kalman_two_state_tracker.sv -----
// Top level of the two-state constant-velocity Kalman tracker.
`timescale 1ns / 1ps
// Each request carries one signed Q16.16 position measurement; the block runs one
// predict, gain and correct step of a constant-velocity Kalman filter and returns the
// corrected position and velocity with a flag that is set when any value clipped. A
// request runs 25 steps from acceptance to its result (the multiplies and accumulates on
// one shared 32x32 multiplier, the divider set-up and finish, and the output load) plus
// a restoring divider that forms both gains side by side, one quotient bit per cycle.
// One request is worked on at a time; a finished result waits in an output register,
// and the next request is taken as soon as the sequence returns to idle, so a new
// request is not accepted until the last one is through. Configuration writes take
// effect at once and should be made only while no request is in flight.
module kalman_two_state_tracker import kt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DataW-1:0]   req_measurement,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DataW-1:0]   rsp_position_estimate,
   output logic signed [DataW-1:0]   rsp_velocity_estimate,
   output logic                      rsp_saturated,
   input  logic                      csr_wr_en,
   input  logic [CsrAddrW-1:0]       csr_addr,
   input  logic [CsrW-1:0]           csr_wdata
);

   cmd_type cmd;

   kt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   kt_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_measurement       (req_measurement),
      .csr_wr_en             (csr_wr_en),
      .csr_addr              (csr_addr),
      .csr_wdata             (csr_wdata),
      .rsp_position_estimate (rsp_position_estimate),
      .rsp_velocity_estimate (rsp_velocity_estimate),
      .rsp_saturated         (rsp_saturated)
   );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the two-state Kalman tracker: directed table, then random requests.
`timescale 1ns / 1ps
module tb_top import kt_pkg::*; ();

   localparam longint DMax = 64'sd2147483647;
   localparam longint DMin = -64'sd2147483648;
   localparam int CycleLimit = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DataW-1:0] req_measurement = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DataW-1:0] rsp_position_estimate;
   logic signed [DataW-1:0] rsp_velocity_estimate;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrW-1:0] csr_wdata = '0;

   kalman_two_state_tracker dut (.*);

   always #1 clock = ~clock;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] vel;
      logic        sat;
   } estimate_type;

   typedef struct {
      bit           is_cfg;
      logic [1:0]   addr;
      logic [30:0]  data;
      logic [31:0]  meas;
      bit           typed;
      estimate_type want;
   } plan_row_type;

   estimate_type pending_estimates[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;

   // Tracker model state and its copy of the registers.
   longint trk_pos, trk_vel, trk_pp, trk_pv, trk_vv;
   longint cfg_qp, cfg_qv, cfg_r, cfg_dt;
   bit step_clip;

   function automatic longint clamp(longint v);
      if (v > DMax) begin step_clip = 1'b1; return DMax; end
      if (v < DMin) begin step_clip = 1'b1; return DMin; end
      return v;
   endfunction

   function automatic longint apply_sign(bit neg, logic [63:0] m);
      logic [63:0] lim;
      lim = 64'(DMax) + 64'(neg);
      if (m > lim) begin step_clip = 1'b1; m = lim; end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint fx_product(longint a, longint b);
      logic [63:0] ua, ub;
      ua = a < 0 ? 64'(-a) : 64'(a);
      ub = b < 0 ? 64'(-b) : 64'(b);
      return apply_sign((a < 0) != (b < 0), (ua * ub) >> FracW);
   endfunction

   function automatic longint fx_quotient(longint n, longint d);
      logic [63:0] un, ud;
      un = n < 0 ? 64'(-n) : 64'(n);
      ud = d < 0 ? 64'(-d) : 64'(d);
      return apply_sign((n < 0) != (d < 0), (un << FracW) / ud);
   endfunction

   function automatic estimate_type track_step(logic [31:0] raw);
      longint z, xp, vp, b00, b01, pp, pv, vv, den, k0, k1, e;
      estimate_type r;
      step_clip = 1'b0;
      z = longint'($signed(raw));
      xp = clamp(trk_pos + fx_product(cfg_dt, trk_vel));
      vp = trk_vel;
      b00 = clamp(trk_pp + fx_product(cfg_dt, trk_pv));
      b01 = clamp(trk_pv + fx_product(cfg_dt, trk_vv));
      pp = clamp(clamp(b00 + fx_product(b01, cfg_dt)) + cfg_qp);
      pv = b01;
      vv = clamp(trk_vv + cfg_qv);
      den = clamp(pp + cfg_r);
      if (den == 0) begin
         k0 = 0;
         k1 = 0;
      end else begin
         k0 = fx_quotient(pp, den);
         k1 = fx_quotient(pv, den);
      end
      e = clamp(z - xp);
      trk_pos = clamp(xp + fx_product(k0, e));
      trk_vel = clamp(vp + fx_product(k1, e));
      trk_pp = clamp(pp - fx_product(k0, pp));
      trk_pv = clamp(pv - fx_product(k0, pv));
      trk_vv = clamp(vv - fx_product(k1, pv));
      r.pos = trk_pos[31:0];
      r.vel = trk_vel[31:0];
      r.sat = step_clip;
      return r;
   endfunction

   task automatic write_reg(logic [1:0] addr, logic [30:0] data);
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (addr)
         CSR_Q_POSITION: cfg_qp = longint'(data);
         CSR_Q_VELOCITY: cfg_qv = longint'(data);
         CSR_MEAS_NOISE: cfg_r = longint'(data);
         CSR_TIME_STEP:  cfg_dt = longint'(data[16:0]);
         default: ;
      endcase
   endtask

   task automatic send_measurement(logic [31:0] meas, bit typed, estimate_type want);
      int gap;
      estimate_type got;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= meas;
      do @(posedge clock); while (req_stall);
      got = track_step(meas);
      pending_estimates.push_back(typed ? want : got);
   endtask

   // Response side: random stall while a result waits, and the comparison.
   int stall_left = 0;
   always @(posedge clock) begin
      estimate_type exp_e;
      int n;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_estimates.size() == 0) begin
               $error("result with no pending request");
               errors++;
            end else begin
               exp_e = pending_estimates.pop_front();
               if (rsp_position_estimate !== exp_e.pos) begin
                  $error("position_estimate expected %h got %h", exp_e.pos,
                         rsp_position_estimate);
                  errors++;
               end
               if (rsp_velocity_estimate !== exp_e.vel) begin
                  $error("velocity_estimate expected %h got %h", exp_e.vel,
                         rsp_velocity_estimate);
                  errors++;
               end
               if (rsp_saturated !== exp_e.sat) begin
                  $error("saturated expected %b got %b", exp_e.sat, rsp_saturated);
                  errors++;
               end
            end
            n = calm ? 0 : $urandom_range(0, 3);
            stall_left <= n;
            rsp_stall <= (n != 0);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= (stall_left > 1);
         end
      end
   end

   plan_row_type plan[23] = '{
      '{0, 0, 0, 32'h00000000, 1, '{32'h0, 32'h0, 1'b0}},
      '{0, 0, 0, 32'h00000000, 1, '{32'h0, 32'h0, 1'b0}},
      '{0, 0, 0, 32'h7fffffff, 0, '0},
      '{0, 0, 0, 32'h80000000, 0, '0},
      '{0, 0, 0, 32'h00000001, 0, '0},
      '{0, 0, 0, 32'hffffffff, 0, '0},
      '{0, 0, 0, 32'h00010000, 0, '0},
      '{0, 0, 0, 32'hfff00000, 0, '0},
      '{1, CSR_Q_POSITION, 31'h7fffffff, 0, 0, '0},
      '{1, CSR_Q_VELOCITY, 31'h7fffffff, 0, 0, '0},
      '{1, CSR_MEAS_NOISE, 31'h7fffffff, 0, 0, '0},
      '{1, CSR_TIME_STEP, 31'd65536, 0, 0, '0},
      '{0, 0, 0, 32'h7fffffff, 0, '0},
      '{0, 0, 0, 32'h80000000, 0, '0},
      '{0, 0, 0, 32'h12345678, 0, '0},
      '{1, CSR_Q_POSITION, 31'd0, 0, 0, '0},
      '{1, CSR_Q_VELOCITY, 31'd0, 0, 0, '0},
      '{1, CSR_MEAS_NOISE, 31'd0, 0, 0, '0},
      '{1, CSR_TIME_STEP, 31'd0, 0, 0, '0},
      // With no noise at all the position variance collapses and the divisor reaches zero.
      '{0, 0, 0, 32'h00050000, 0, '0},
      '{0, 0, 0, 32'h00050000, 0, '0},
      '{0, 0, 0, 32'h00050000, 0, '0},
      '{0, 0, 0, 32'h80000000, 0, '0}
   };

   initial begin
      longint path_pos, path_vel;
      logic [31:0] m;
      int pick;
      trk_pos = 0; trk_vel = 0; trk_pp = 655; trk_pv = 0; trk_vv = 655;
      cfg_qp = 1966; cfg_qv = 1966; cfg_r = 2949; cfg_dt = 262;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_reg(plan[i].addr, plan[i].data);
         else send_measurement(plan[i].meas, plan[i].typed, plan[i].want);
      end
      path_pos = 0;
      path_vel = 0;
      for (int i = 0; i < 400; i++) begin
         if (i % 80 == 0) begin
            pick = $urandom_range(0, 3);
            for (int a = 0; a < 4; a++) begin
               case (pick)
                  0: write_reg(a[1:0], a == 3 ? 31'd262 : (a == 2 ? 31'd2949 : 31'd1966));
                  1: write_reg(a[1:0], 31'($urandom));
                  2: write_reg(a[1:0], a == 3 ? 31'($urandom_range(0, 65536))
                                              : 31'($urandom_range(0, 32'h40000)));
                  default: write_reg(a[1:0], a == 3 ? 31'd65536 : 31'h7fffffff);
               endcase
            end
            path_pos = 0;
         end
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            path_vel = $signed($urandom_range(0, 32'h20000)) - 64'sh10000;
            path_pos = path_pos + path_vel;
            if (path_pos > DMax || path_pos < DMin) path_pos = 0;
            m = 32'(path_pos + ($signed($urandom_range(0, 32'h4000)) - 64'sh2000));
         end else if (pick < 88) begin
            m = $urandom;
         end else begin
            case ($urandom_range(0, 3))
               0: m = 32'h7fffffff;
               1: m = 32'h80000000;
               2: m = 32'h00000000;
               default: m = 32'hffffffff;
            endcase
         end
         send_measurement(m, 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kt_pkg.sv
rtl/kt_datapath.sv
rtl/kt_ctrl.sv
rtl/kalman_two_state_tracker.sv
sim/tb_top.sv
